>>> src/tla_pkg.sv
package tla_pkg;

  // field and datapath widths
  localparam int COUNT_W    = 10;
  localparam int COEFF_W    = 32;
  localparam int TEMP_W     = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int POLY_W     = 64;
  localparam int POLY_SHIFT = 42;
  localparam int RAW_W      = POLY_W - POLY_SHIFT;

  // result status codes
  typedef enum logic [1:0] {
    ST_AVERAGED   = 2'd0,
    ST_COUNT_HIGH = 2'd1,
    ST_COUNT_LOW  = 2'd2,
    ST_HELD       = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT_LOW    = 3'd0,
    REG_COUNT_HIGH   = 3'd1,
    REG_COEFF_ZERO   = 3'd2,
    REG_COEFF_ONE    = 3'd3,
    REG_COEFF_TWO    = 3'd4,
    REG_COEFF_THREE  = 3'd5,
    REG_TEMP_FLOOR   = 3'd6,
    REG_TEMP_CEILING = 3'd7
  } reg_index_t;

  // core sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_POLY,
    S_CHECK,
    S_STORE,
    S_DIV,
    S_DONE
  } state_t;

  // cubic coefficients, signed Q12.20
  typedef struct packed {
    logic signed [COEFF_W-1:0] c3;
    logic signed [COEFF_W-1:0] c2;
    logic signed [COEFF_W-1:0] c1;
    logic signed [COEFF_W-1:0] c0;
  } coeff_t;

endpackage

>>> src/thermistor_linearizer_averager.sv
// Thermistor linearizer with moving average. Each item is one 10-bit converter count;
// the result is a signed Q8.8 temperature with a status (averaged, count too high,
// count too low, held). Counts outside the count limits skip straight to the result.
// In-range counts run the cubic through a bit-serial Horner unit (three passes over
// the 10 count bits on a 64-bit shift-add accumulator), a range check and ring read
// (S_CHECK), a ring and sum update (S_STORE), then a restoring divider by RING_DEPTH.
// One item is in work at a time; a new item is taken while the previous result waits
// in the output register. Configuration writes land at once and are expected only
// while the block is idle.
module thermistor_linearizer_averager
  import tla_pkg::*;
#(
  parameter int RING_DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COUNT_W-1:0]       adc_count,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] temperature,
  output logic [1:0]               status
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int SUM_W = TEMP_W + PTR_W;

  // configuration registers
  logic [COUNT_W-1:0]       count_low_limit;
  logic [COUNT_W-1:0]       count_high_limit;
  coeff_t                   coeff;
  logic signed [TEMP_W-1:0] temp_floor;
  logic signed [TEMP_W-1:0] temp_ceiling;

  // core state
  state_t                   state;
  state_t                   state_next;
  logic [COUNT_W-1:0]       cnt;
  logic signed [RAW_W-1:0]  t_val;
  logic signed [TEMP_W-1:0] res_temp;
  status_t                  res_status;
  logic signed [TEMP_W-1:0] held;
  logic [PTR_W-1:0]         ptr;
  logic [PTR_W-1:0]         ptr_nx;
  logic signed [SUM_W-1:0]  ring_sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic [RING_DEPTH-1:0]    ring_valid;
  logic signed [TEMP_W-1:0] ring [RING_DEPTH];
  logic signed [TEMP_W-1:0] rd_data;
  logic signed [TEMP_W-1:0] old_val;

  // control strobes
  logic                     count_high;
  logic                     count_low;
  logic                     in_range;
  logic                     poly_start;
  logic                     poly_done;
  logic signed [RAW_W-1:0]  poly_raw;
  logic                     div_start;
  logic                     div_done;
  logic signed [TEMP_W-1:0] div_quot;
  logic                     rd_en;
  logic                     wr_en;
  logic                     load_out;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      count_low_limit  <= COUNT_W'(151);
      count_high_limit <= COUNT_W'(908);
      coeff            <= '0;
      temp_floor       <= -TEMP_W'(3840);
      temp_ceiling     <= TEMP_W'(19200);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_COUNT_LOW:    count_low_limit  <= cfg_data[COUNT_W-1:0];
        REG_COUNT_HIGH:   count_high_limit <= cfg_data[COUNT_W-1:0];
        REG_COEFF_ZERO:   coeff.c0         <= cfg_data[COEFF_W-1:0];
        REG_COEFF_ONE:    coeff.c1         <= cfg_data[COEFF_W-1:0];
        REG_COEFF_TWO:    coeff.c2         <= cfg_data[COEFF_W-1:0];
        REG_COEFF_THREE:  coeff.c3         <= cfg_data[COEFF_W-1:0];
        REG_TEMP_FLOOR:   temp_floor       <= cfg_data[TEMP_W-1:0];
        REG_TEMP_CEILING: temp_ceiling     <= cfg_data[TEMP_W-1:0];
        default:          ;
      endcase
    end
  end

  // classification of the count and of the polynomial value
  assign count_high = (cnt > count_high_limit);
  assign count_low  = (cnt < count_low_limit);
  assign in_range   =
      !(t_val > $signed({{(RAW_W-TEMP_W){temp_ceiling[TEMP_W-1]}}, temp_ceiling}))
   && !(t_val < $signed({{(RAW_W-TEMP_W){temp_floor[TEMP_W-1]}}, temp_floor}));

  // ring pointer advance and sum update
  assign ptr_nx   = (ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign old_val  = ring_valid[ptr] ? rd_data : '0;
  assign sum_next = ring_sum
                  - {{(SUM_W-TEMP_W){old_val[TEMP_W-1]}}, old_val}
                  + {{(SUM_W-TEMP_W){t_val[TEMP_W-1]}}, t_val[TEMP_W-1:0]};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_CLASS;
      S_CLASS: state_next = (count_high || count_low) ? S_DONE : S_POLY;
      S_POLY:  if (poly_done) state_next = S_CHECK;
      S_CHECK: state_next = in_range ? S_STORE : S_DONE;
      S_STORE: state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    poly_start = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE:  in_ready   = 1'b1;
      S_CLASS: poly_start = !(count_high || count_low);
      S_POLY:  ;
      S_CHECK: rd_en      = in_range;
      S_STORE: begin
        wr_en     = 1'b1;
        div_start = 1'b1;
      end
      S_DIV:   ;
      S_DONE:  load_out   = !out_valid || out_ready;
      default: ;
    endcase
  end

  // item payload through the core
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cnt <= adc_count;
    end
    if (state == S_CLASS) begin
      if (count_high) begin
        res_temp   <= temp_floor;
        res_status <= ST_COUNT_HIGH;
      end else if (count_low) begin
        res_temp   <= temp_ceiling;
        res_status <= ST_COUNT_LOW;
      end
    end
    if (poly_done) begin
      t_val <= poly_raw;
    end
    if (state == S_CHECK && !in_range) begin
      res_temp   <= held;
      res_status <= ST_HELD;
    end
    if (div_done) begin
      res_temp   <= div_quot;
      res_status <= ST_AVERAGED;
    end
  end

  // ring bookkeeping and last answer
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      ring_sum   <= '0;
      ring_valid <= '0;
      held       <= '0;
    end else begin
      if (rd_en) begin
        ptr <= ptr_nx;
      end
      if (wr_en) begin
        ring_sum        <= sum_next;
        ring_valid[ptr] <= 1'b1;
      end
      if (load_out) begin
        held <= res_temp;
      end
    end
  end

  // sample ring memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[ptr] <= t_val[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ring[ptr_nx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      temperature <= res_temp;
      status      <= res_status;
    end
  end

  // bit-serial cubic evaluation
  tla_poly u_poly (
    .clk   (clk),
    .rst   (rst),
    .start (poly_start),
    .count (cnt),
    .coeff (coeff),
    .done  (poly_done),
    .raw   (poly_raw)
  );

  // serial floor division of the ring sum
  tla_div #(
    .DEPTH (RING_DEPTH),
    .SUM_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (sum_next),
    .done  (div_done),
    .quot  (div_quot)
  );

`ifndef SYNTH
  // polynomial result only arrives while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst) poly_done |-> state == S_POLY)
    else $error("polynomial done outside wait state");

  // division result only arrives while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == S_DIV)
    else $error("divider done outside wait state");

  // a stored entry is marked valid
  assert property (@(posedge clk) disable iff (rst) state == S_STORE |=> ring_valid[ptr])
    else $error("ring entry not marked valid after store");

  // a new result only comes from a finished item
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result loaded without a finished item");
`endif

endmodule

>>> src/tla_poly.sv
module tla_poly
  import tla_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [COUNT_W-1:0]      count,
  input  coeff_t                  coeff,
  output logic                    done,
  output logic signed [RAW_W-1:0] raw
);

  localparam int BIT_W = $clog2(COUNT_W);

  logic signed [POLY_W-1:0] acc;
  logic signed [POLY_W-1:0] part;
  logic signed [POLY_W-1:0] step;
  logic [BIT_W-1:0]         bit_idx;
  logic [1:0]               pass;
  logic                     busy;
  logic                     last_bit;

  // msb-first shift-add of the accumulator by one bit of the count
  assign step     = (part <<< 1) + (count[bit_idx] ? acc : '0);
  assign last_bit = busy && (bit_idx == '0);

  // control: three horner passes of COUNT_W bits each
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (last_bit && pass == 2'd2) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: partial product starts at the next term, shifted left by 10 more bits each pass
  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= {{(POLY_W-COEFF_W){coeff.c3[COEFF_W-1]}}, coeff.c3};
      part    <= {{(POLY_W-COEFF_W){coeff.c2[COEFF_W-1]}}, coeff.c2};
      pass    <= 2'd0;
      bit_idx <= BIT_W'(COUNT_W - 1);
    end else if (busy) begin
      if (bit_idx == '0) begin
        acc     <= step;
        pass    <= pass + 2'd1;
        bit_idx <= BIT_W'(COUNT_W - 1);
        if (pass == 2'd0) begin
          part <= {{(POLY_W-COEFF_W-10){coeff.c1[COEFF_W-1]}}, coeff.c1, 10'b0};
        end else begin
          part <= {{(POLY_W-COEFF_W-20){coeff.c0[COEFF_W-1]}}, coeff.c0, 20'b0};
        end
        if (pass == 2'd2) begin
          raw <= step[POLY_W-1:POLY_SHIFT];
        end
      end else begin
        part    <= step;
        bit_idx <= bit_idx - 1'b1;
      end
    end
  end

endmodule

>>> src/tla_div.sv
module tla_div
  import tla_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int SUM_W = 19
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [SUM_W-1:0]  sum,
  output logic                     done,
  output logic signed [TEMP_W-1:0] quot
);

  localparam int REM_W = $clog2(DEPTH);
  localparam int MAG_W = SUM_W - 1;
  localparam int CNT_W = $clog2(MAG_W);
  localparam logic [REM_W:0] DIVISOR = (REM_W+1)'(DEPTH);

  logic [MAG_W-1:0] mag;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             neg;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             fits;
  logic [MAG_W-1:0] q_last;

  // one restoring division step per cycle
  assign trial  = {rem, mag[MAG_W-1]};
  assign diff   = trial - DIVISOR;
  assign fits   = (trial >= DIVISOR);
  assign q_last = {mag[MAG_W-2:0], fits};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // floor division: negative sums divide their complement, then invert
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= sum[SUM_W-1];
      mag <= sum[SUM_W-1] ? ~sum[MAG_W-1:0] : sum[MAG_W-1:0];
      rem <= '0;
      cnt <= CNT_W'(MAG_W - 1);
    end else if (busy) begin
      mag <= q_last;
      rem <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        quot <= neg ? ~q_last[TEMP_W-1:0] : q_last[TEMP_W-1:0];
      end
    end
  end

endmodule
